// ===== sv/ljpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpe_pkg
// Shared types and constants for the Lennard-Jones pair energy pipeline.
// ----------------------------------------------------------------------------
package ljpe_pkg;

    localparam int unsigned RECIP_BITS = 22;   // quotient bits of 2^48 / S
    localparam int unsigned DIV_WIDTH  = 50;   // divisor and remainder width
    localparam int unsigned SQ_WIDTH   = 64;   // squared distance, 32 frac bits
    localparam int unsigned CFG_WIDTH  = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [SQ_WIDTH-1:0]  NEAR_LIMIT = 64'd67108864;    // 2^26
    localparam logic [DIV_WIDTH-1:0] RECIP_REM0 = 50'd67108864;    // 2^48 >> 22

    localparam logic signed [31:0] ENERGY_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] ENERGY_MIN = 32'sh80000000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOX_LENGTH      = 3'd0,
        CFG_WRAP_ENABLE     = 3'd1,
        CFG_CUTOFF_SQUARED  = 3'd2,
        CFG_ENERGY_SCALE    = 3'd3,
        CFG_POTENTIAL_SHIFT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic in_range; // squared distance below cutoff
        logic huge;     // energy certain to overflow
    } ljpe_flags_t;

endpackage

// ===== sv/lj_pair_energy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_pair_energy
// Truncated and shifted Lennard-Jones pair energy, one pair per cycle.
// Register stages: 5 geometry, 22 divider bit stages, 8 energy stages.
// Throughput: one item per cycle; the whole pipeline holds while the output
// item is not taken. Synchronous active-low reset clears all valid bits and
// loads the register defaults.
// ----------------------------------------------------------------------------
module lj_pair_energy #(
    parameter int DIMENSIONS  = 3,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ljpe_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ljpe_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_WIDTH-1:0]         s_ax,
    input  logic signed [COORD_WIDTH-1:0]         s_ay,
    input  logic signed [COORD_WIDTH-1:0]         s_az,
    input  logic signed [COORD_WIDTH-1:0]         s_bx,
    input  logic signed [COORD_WIDTH-1:0]         s_by,
    input  logic signed [COORD_WIDTH-1:0]         s_bz,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [31:0]                    m_pair_energy,
    output logic                                  m_within_cutoff,
    output logic                                  m_saturated
);
    import ljpe_pkg::*;

    logic [23:0]         box_length_reg;
    logic                wrap_enable_reg;
    logic [31:0]         cutoff_squared_reg;
    logic [31:0]         energy_scale_reg;
    logic signed [31:0]  potential_shift_reg;

    logic                ce;
    logic signed [COORD_WIDTH-1:0] a_pos [3];
    logic signed [COORD_WIDTH-1:0] b_pos [3];
    logic                geom_valid;
    ljpe_flags_t         geom_flags;
    logic [DIV_WIDTH-1:0] geom_divisor;
    logic                recip_valid;
    ljpe_flags_t         recip_flags;
    logic [RECIP_BITS-1:0] recip_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_length_reg      <= 24'd655360;
            wrap_enable_reg     <= 1'b1;
            cutoff_squared_reg  <= 32'd409600;
            energy_scale_reg    <= 32'd262144;
            potential_shift_reg <= -32'sd267;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_BOX_LENGTH:      box_length_reg      <= cfg_data[23:0];
                CFG_WRAP_ENABLE:     wrap_enable_reg     <= cfg_data[0];
                CFG_CUTOFF_SQUARED:  cutoff_squared_reg  <= cfg_data;
                CFG_ENERGY_SCALE:    energy_scale_reg    <= cfg_data;
                CFG_POTENTIAL_SHIFT: potential_shift_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    assign a_pos[0] = s_ax;
    assign a_pos[1] = s_ay;
    assign a_pos[2] = s_az;
    assign b_pos[0] = s_bx;
    assign b_pos[1] = s_by;
    assign b_pos[2] = s_bz;

    ljpe_geom #(
        .DIMENSIONS  (DIMENSIONS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_geom (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ce             (ce),
        .in_valid       (s_valid),
        .a              (a_pos),
        .b              (b_pos),
        .box_length     (box_length_reg),
        .wrap_enable    (wrap_enable_reg),
        .cutoff_squared (cutoff_squared_reg),
        .out_valid      (geom_valid),
        .out_flags      (geom_flags),
        .out_divisor    (geom_divisor)
    );

    ljpe_recip u_recip (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (geom_valid),
        .in_flags   (geom_flags),
        .in_divisor (geom_divisor),
        .out_valid  (recip_valid),
        .out_flags  (recip_flags),
        .out_recip  (recip_value)
    );

    ljpe_poly u_poly (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ce              (ce),
        .in_valid        (recip_valid),
        .in_flags        (recip_flags),
        .in_recip        (recip_value),
        .energy_scale    (energy_scale_reg),
        .potential_shift (potential_shift_reg),
        .out_valid       (m_valid),
        .out_energy      (m_pair_energy),
        .out_within      (m_within_cutoff),
        .out_saturated   (m_saturated)
    );

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_within_cutoff |-> m_pair_energy == '0 && !m_saturated)
        else $error("energy beyond cutoff not zero");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_pair_energy == ENERGY_MAX || m_pair_energy == ENERGY_MIN)
        else $error("saturated item not clamped");

    a_zero_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && energy_scale_reg == '0 |-> m_pair_energy == '0 && !m_saturated)
        else $error("zero scale gave nonzero energy");

endmodule

// ===== sv/ljpe_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpe_geom
// Separation, minimum-image wrap, squares and saturating sum, cutoff test.
// Five register stages.
// ----------------------------------------------------------------------------
module ljpe_geom #(
    parameter int DIMENSIONS  = 3,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 ce,
    input  logic                                 in_valid,
    input  logic signed [COORD_WIDTH-1:0]        a [3],
    input  logic signed [COORD_WIDTH-1:0]        b [3],
    input  logic [23:0]                          box_length,
    input  logic                                 wrap_enable,
    input  logic [31:0]                          cutoff_squared,
    output logic                                 out_valid,
    output ljpe_pkg::ljpe_flags_t                out_flags,
    output logic [ljpe_pkg::DIV_WIDTH-1:0]       out_divisor
);
    import ljpe_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int MW = COORD_WIDTH + 2;
    localparam int EW = (COORD_WIDTH + 3 > 26) ? COORD_WIDTH + 3 : 26;

    logic signed [DW-1:0]   d_reg [DIMENSIONS];
    logic [MW-1:0]          m_reg [DIMENSIONS];
    logic [MW-1:0]          m_next [DIMENSIONS];
    logic [SQ_WIDTH-1:0]    sq_reg [DIMENSIONS];
    logic [SQ_WIDTH-1:0]    sq_next [DIMENSIONS];
    logic [SQ_WIDTH-1:0]    s_reg;
    logic [SQ_WIDTH-1:0]    s_next;
    logic [4:0]             v_reg;
    ljpe_flags_t            flags_reg;
    ljpe_flags_t            flags_next;
    logic [DIV_WIDTH-1:0]   div_reg;
    logic [DIV_WIDTH-1:0]   div_next;

    always_comb begin
        logic signed [EW-1:0] dx;
        logic signed [EW-1:0] lx;
        logic signed [EW-1:0] w;
        logic [33:0]          m34;
        logic [SQ_WIDTH+1:0]  acc;
        dx = '0;
        lx = signed'(EW'(box_length));
        w = '0;
        m34 = '0;
        for (int i = 0; i < DIMENSIONS; i++) begin
            dx = EW'(d_reg[i]);
            w = dx;
            if (wrap_enable && ((dx <<< 1) > lx)) begin
                w = dx - lx;
            end else if (wrap_enable && ((dx <<< 1) < -lx)) begin
                w = dx + lx;
            end
            m_next[i] = (w < 0) ? MW'(-w) : MW'(w);
        end
        for (int i = 0; i < DIMENSIONS; i++) begin
            m34 = 34'(m_reg[i]);
            if (m34[33:32] != 2'b00) begin
                sq_next[i] = '1;
            end else begin
                sq_next[i] = 64'(m34[31:0]) * 64'(m34[31:0]);
            end
        end
        acc = '0;
        for (int i = 0; i < DIMENSIONS; i++) begin
            acc = acc + 66'(sq_reg[i]);
        end
        s_next = (acc[SQ_WIDTH+1:SQ_WIDTH] != 2'b00) ? '1 : acc[SQ_WIDTH-1:0];
        flags_next.in_range = s_reg < {16'd0, cutoff_squared, 16'd0};
        flags_next.huge     = s_reg <= NEAR_LIMIT;
        div_next = (s_reg[SQ_WIDTH-1:DIV_WIDTH] != '0) ? '1 : s_reg[DIV_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < DIMENSIONS; i++) begin
                d_reg[i]  <= DW'(a[i]) - DW'(b[i]);
                m_reg[i]  <= m_next[i];
                sq_reg[i] <= sq_next[i];
            end
            s_reg     <= s_next;
            flags_reg <= flags_next;
            div_reg   <= div_next;
        end
    end

    assign out_valid   = v_reg[4];
    assign out_flags   = flags_reg;
    assign out_divisor = div_reg;

endmodule

// ===== sv/ljpe_recip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpe_recip
// Pipelined restoring divider: floor(2^48 / S), one quotient bit per stage.
// ----------------------------------------------------------------------------
module ljpe_recip (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              in_valid,
    input  ljpe_pkg::ljpe_flags_t             in_flags,
    input  logic [ljpe_pkg::DIV_WIDTH-1:0]    in_divisor,
    output logic                              out_valid,
    output ljpe_pkg::ljpe_flags_t             out_flags,
    output logic [ljpe_pkg::RECIP_BITS-1:0]   out_recip
);
    import ljpe_pkg::*;

    logic [DIV_WIDTH-1:0]  r_reg [RECIP_BITS];
    logic [DIV_WIDTH-1:0]  d_reg [RECIP_BITS];
    logic [RECIP_BITS-1:0] q_reg [RECIP_BITS];
    ljpe_flags_t           f_reg [RECIP_BITS];
    logic [RECIP_BITS-1:0] v_reg;

    logic [DIV_WIDTH-1:0]  r_in [RECIP_BITS];
    logic [DIV_WIDTH-1:0]  d_in [RECIP_BITS];
    logic [RECIP_BITS-1:0] q_in [RECIP_BITS];
    ljpe_flags_t           f_in [RECIP_BITS];
    logic [DIV_WIDTH-1:0]  r_next [RECIP_BITS];
    logic [RECIP_BITS-1:0] q_next [RECIP_BITS];

    always_comb begin
        logic [DIV_WIDTH-1:0] r2;
        r2 = '0;
        for (int j = 0; j < RECIP_BITS; j++) begin
            if (j == 0) begin
                r_in[j] = RECIP_REM0;
                d_in[j] = in_divisor;
                q_in[j] = '0;
                f_in[j] = in_flags;
            end else begin
                r_in[j] = r_reg[j-1];
                d_in[j] = d_reg[j-1];
                q_in[j] = q_reg[j-1];
                f_in[j] = f_reg[j-1];
            end
            r2 = {r_in[j][DIV_WIDTH-2:0], 1'b0};
            if (r2 >= d_in[j]) begin
                r_next[j] = r2 - d_in[j];
                q_next[j] = {q_in[j][RECIP_BITS-2:0], 1'b1};
            end else begin
                r_next[j] = r2;
                q_next[j] = {q_in[j][RECIP_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[RECIP_BITS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int j = 0; j < RECIP_BITS; j++) begin
                r_reg[j] <= r_next[j];
                d_reg[j] <= d_in[j];
                q_reg[j] <= q_next[j];
                f_reg[j] <= f_in[j];
            end
        end
    end

    assign out_valid = v_reg[RECIP_BITS-1];
    assign out_flags = f_reg[RECIP_BITS-1];
    assign out_recip = q_reg[RECIP_BITS-1];

endmodule

// ===== sv/ljpe_poly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpe_poly
// Inverse powers r^-4, r^-6, r^-12, shifted difference, scaling and clamp.
// Eight register stages, the last one is the output register.
// ----------------------------------------------------------------------------
module ljpe_poly (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              in_valid,
    input  ljpe_pkg::ljpe_flags_t             in_flags,
    input  logic [ljpe_pkg::RECIP_BITS-1:0]   in_recip,
    input  logic [31:0]                       energy_scale,
    input  logic signed [31:0]                potential_shift,
    output logic                              out_valid,
    output logic signed [31:0]                out_energy,
    output logic                              out_within,
    output logic                              out_saturated
);
    import ljpe_pkg::*;

    logic [7:0]        v_reg;
    ljpe_flags_t       f_reg [7];
    logic [21:0]       i2a_reg;
    logic [27:0]       i4_reg;
    logic [21:0]       i2b_reg;
    logic [31:0]       i6a_reg;
    logic [31:0]       i6b_reg;
    logic [47:0]       i12_reg;
    logic              neg_reg [3];
    logic [49:0]       mag_reg;
    logic [56:0]       plo_reg;
    logic [56:0]       phi_reg;
    logic [65:0]       q_reg;
    logic signed [31:0] energy_reg;
    logic              sat_reg;
    logic              within_reg;

    logic [43:0]       p44;
    logic [49:0]       p50;
    logic [33:0]       i6_full;
    logic [63:0]       p64;
    logic signed [50:0] diff;
    logic [81:0]       prod;
    ljpe_flags_t       f2_next;
    logic signed [31:0] energy_next;
    logic              sat_next;

    always_comb begin
        p44 = 44'(i2a_reg) * 44'(i2a_reg);
        p50 = 50'(i4_reg) * 50'(i2b_reg);
        i6_full = p50[49:16];
        f2_next = f_reg[1];
        f2_next.huge = f_reg[1].huge | (i6_full[33:32] != 2'b00);
        p64 = 64'(i6a_reg) * 64'(i6a_reg);
        diff = 51'(i12_reg) - 51'(i6b_reg) - 51'(potential_shift);
        prod = (82'(phi_reg) << 25) + 82'(plo_reg);
        energy_next = '0;
        sat_next = 1'b0;
        if (!f_reg[6].in_range || energy_scale == '0) begin
            energy_next = '0;
        end else if (f_reg[6].huge) begin
            energy_next = ENERGY_MAX;
            sat_next = 1'b1;
        end else if (neg_reg[2]) begin
            if (q_reg > 66'h80000000) begin
                energy_next = ENERGY_MIN;
                sat_next = 1'b1;
            end else begin
                energy_next = -signed'(q_reg[31:0]);
            end
        end else begin
            if (q_reg > 66'h7FFFFFFF) begin
                energy_next = ENERGY_MAX;
                sat_next = 1'b1;
            end else begin
                energy_next = signed'(q_reg[31:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_reg[0] <= in_flags;
            i2a_reg  <= in_recip;
            i4_reg   <= p44[43:16];
            i2b_reg  <= i2a_reg;
            f_reg[1] <= f_reg[0];
            i6a_reg  <= i6_full[31:0];
            f_reg[2] <= f2_next;
            i12_reg  <= p64[63:16];
            i6b_reg  <= i6a_reg;
            f_reg[3] <= f_reg[2];
            neg_reg[0] <= diff < 0;
            mag_reg  <= (diff < 0) ? 50'(-diff) : 50'(diff);
            f_reg[4] <= f_reg[3];
            neg_reg[1] <= neg_reg[0];
            plo_reg  <= 57'(energy_scale) * 57'(mag_reg[24:0]);
            phi_reg  <= 57'(energy_scale) * 57'(mag_reg[49:25]);
            f_reg[5] <= f_reg[4];
            neg_reg[2] <= neg_reg[1];
            q_reg    <= prod[81:16];
            f_reg[6] <= f_reg[5];
            energy_reg <= energy_next;
            sat_reg    <= sat_next;
            within_reg <= f_reg[6].in_range;
        end
    end

    assign out_valid     = v_reg[7];
    assign out_energy    = energy_reg;
    assign out_within    = within_reg;
    assign out_saturated = sat_reg;

endmodule
